// ----- hdl/slt_pkg.sv -----
// Shared types and codes for the sorted list table.
package slt_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_SEARCH = 2'd1;
	localparam kind_t KIND_REMOVE = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_DONE   = 2'd0;
	localparam status_t STATUS_FULL   = 2'd1;
	localparam status_t STATUS_ABSENT = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_UP   = 5'b00100,
		ST_DOWN = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

// ----- hdl/slt_req_if.sv -----
// Request channel: operation kind and operand value.
interface slt_req_if;
	import slt_pkg::*;

	logic                       valid;
	logic                       ready;
	kind_t                      kind;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- hdl/slt_rsp_if.sv -----
// Response channel: match flag, status, entry count and empty flag.
interface slt_rsp_if;
	import slt_pkg::*;

	logic                valid;
	logic                ready;
	logic                found;
	status_t             status;
	logic [COUNT_W-1:0]  entry_count;
	logic                is_empty;

	modport source (output valid, output found, output status, output entry_count,
		output is_empty, input ready);
	modport sink   (input valid, input found, input status, input entry_count,
		input is_empty, output ready);
endinterface

// ----- hdl/slt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/sorted_list_table_unit.sv -----
// Sorted list table: bounded ascending table of signed values, one RAM, one comparator.
//
//   req carries kind (insert, search, remove) and a signed value. A beat is
//   taken only while the unit is idle; ready drops for the whole operation.
//   rsp returns one beat per request: found, status, entry_count, is_empty.
//   Operations walk the table RAM one entry per cycle through a single
//   comparator: a linear scan finds the first entry >= value, then entries
//   are moved one slot per cycle to open or close a gap.
//   Search and a remove miss end after the scan; an insert then shifts the
//   entries from the match position on up one slot and writes the value;
//   a remove hit shifts the entries after the match down one slot. Insert
//   on full and unused kinds skip the table and go straight to the result.
//   One item at a time; the next request can be taken in the cycle after
//   the result is registered.
//   The result sits in an output register, so a new request is taken while
//   a previous result waits; a stalled rsp holds the next result in the
//   final state until the register frees up.
//   Reset empties the table (count to zero); RAM contents are not cleared.
module sorted_list_table_unit #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	slt_req_if.sink   req,
	slt_rsp_if.source rsp
);
	import slt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                        state_q;
	kind_t                         kind_q;
	logic signed [VALUE_BITS-1:0]  key_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 cidx_q;
	logic [CW-1:0]                 rem_q;
	logic [CW-1:0]                 pos_q;
	logic                          pend_q;
	logic                          res_found_q;
	status_t                       res_status_q;

	logic                          rsp_valid_q;
	logic                          rsp_found_q;
	status_t                       rsp_status_q;
	logic [COUNT_W-1:0]            rsp_count_q;
	logic                          rsp_empty_q;

	logic signed [VALUE_BITS-1:0]  rd_data;
	logic                          rd_ge;
	logic                          rd_eq;
	logic                          scan_hit;
	logic                          scan_end;
	logic [CW-1:0]                 scan_pos;
	logic                          scan_eq;
	logic [CW-1:0]                 up_addr;
	logic [CW-1:0]                 dn_addr;
	logic                          we;
	logic [AW-1:0]                 waddr;
	logic [VALUE_BITS-1:0]         wdata;
	logic                          fin_take;

	slt_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	// shared comparator
	assign rd_ge = rd_data >= key_q;
	assign rd_eq = rd_data == key_q;

	// pend_q marks that rd_data holds entry cidx_q
	assign scan_hit = pend_q && rd_ge;
	assign scan_end = !pend_q && (idx_q >= cnt_q);
	assign scan_pos = scan_hit ? cidx_q : cnt_q;
	assign scan_eq  = scan_hit && rd_eq;

	assign up_addr  = cidx_q + CW'(1);
	assign dn_addr  = cidx_q - CW'(1);
	assign fin_take = !rsp_valid_q || rsp.ready;

	always_comb begin
		we    = 1'b0;
		waddr = up_addr[AW-1:0];
		wdata = rd_data;
		unique case (state_q)
			ST_UP: begin
				if (pend_q) begin
					we = 1'b1;
				end else if (rem_q == '0) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = key_q;
				end
			end
			ST_DOWN: begin
				we    = pend_q;
				waddr = dn_addr[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_INSERT;
			key_q        <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			cidx_q       <= '0;
			rem_q        <= '0;
			pos_q        <= '0;
			pend_q       <= 1'b0;
			res_found_q  <= 1'b0;
			res_status_q <= STATUS_DONE;
			rsp_valid_q  <= 1'b0;
			rsp_found_q  <= 1'b0;
			rsp_status_q <= STATUS_DONE;
			rsp_count_q  <= '0;
			rsp_empty_q  <= 1'b1;
		end else begin
			// in ST_FIN a taken beat is replaced by the next result
			if (rsp_valid_q && rsp.ready && state_q != ST_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						kind_q       <= req.kind;
						key_q        <= VALUE_BITS'(req.value);
						idx_q        <= '0;
						pend_q       <= 1'b0;
						res_found_q  <= 1'b0;
						res_status_q <= STATUS_DONE;
						if (req.kind == KIND_INSERT && cnt_q == CW'(CAPACITY)) begin
							res_status_q <= STATUS_FULL;
							state_q      <= ST_FIN;
						end else if (req.kind == KIND_INSERT || req.kind == KIND_SEARCH ||
							req.kind == KIND_REMOVE) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_hit || scan_end) begin
						pos_q  <= scan_pos;
						pend_q <= 1'b0;
						if (kind_q == KIND_INSERT) begin
							rem_q   <= cnt_q - scan_pos;
							idx_q   <= cnt_q - CW'(1);
							state_q <= ST_UP;
						end else if (kind_q == KIND_REMOVE && scan_eq) begin
							rem_q        <= cnt_q - scan_pos - CW'(1);
							idx_q        <= scan_pos + CW'(1);
							res_found_q  <= 1'b1;
							state_q      <= ST_DOWN;
						end else begin
							res_found_q  <= scan_eq;
							res_status_q <= scan_eq ? STATUS_DONE : STATUS_ABSENT;
							state_q      <= ST_FIN;
						end
					end else begin
						pend_q <= idx_q < cnt_q;
						cidx_q <= idx_q;
						idx_q  <= idx_q + CW'(1);
					end
				end
				ST_UP: begin
					if (rem_q != '0) begin
						pend_q <= 1'b1;
						cidx_q <= idx_q;
						idx_q  <= idx_q - CW'(1);
						rem_q  <= rem_q - CW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= ST_FIN;
						end
					end
				end
				ST_DOWN: begin
					if (rem_q != '0) begin
						pend_q <= 1'b1;
						cidx_q <= idx_q;
						idx_q  <= idx_q + CW'(1);
						rem_q  <= rem_q - CW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_take) begin
						rsp_valid_q  <= 1'b1;
						rsp_found_q  <= res_found_q;
						rsp_status_q <= res_status_q;
						rsp_count_q  <= COUNT_W'(cnt_q);
						rsp_empty_q  <= cnt_q == '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = state_q == ST_IDLE;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.is_empty    = rsp_empty_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> $past(state_q) == ST_UP || $past(state_q) == ST_DOWN)
		else $error("entry count changed outside a move phase");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an operation was starting");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == STATUS_DONE)
		else $error("match reported with a failure status");
`endif
endmodule

// ----- sim/tb_sorted_list_table_unit.sv -----
// Testbench for sorted_list_table_unit: random and directed table operations checked beat by beat.
`timescale 1ns / 1ps

module tb_sorted_list_table_unit;
	import slt_pkg::*;

	localparam int      DEPTH       = 16;
	localparam int      RANDOM_OPS  = 700;
	localparam int      CYCLE_LIMIT = 400000;
	localparam int      MAX_REPORTS = 20;
	localparam kind_t   KIND_UNUSED = 2'd3;

	typedef struct {
		kind_t                      kind;
		logic signed [VALUE_W-1:0]  value;
	} table_op_t;

	typedef struct {
		logic                found;
		status_t             status;
		logic [COUNT_W-1:0]  count;
		logic                empty;
	} outcome_t;

	logic clk;
	logic arst_n;

	slt_req_if req_ch ();
	slt_rsp_if rsp_ch ();

	sorted_list_table_unit #(
		.CAPACITY   (DEPTH),
		.VALUE_BITS (VALUE_W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	table_op_t                  pending_ops[$];
	outcome_t                   expected_outcomes[$];
	logic signed [VALUE_W-1:0]  shadow_table[$];
	int                         cyc;
	int                         ops_taken;
	int                         errors;
	logic                       beat_taken;
	logic                       calm;

	// long stretch with no idling on either side
	assign calm = (ops_taken >= 350) && (ops_taken < 500);

	// Applies one operation to the shadow table and returns the answer the unit should give.
	function automatic outcome_t apply_op(table_op_t op);
		outcome_t r;
		int       pos;
		r.found  = 1'b0;
		r.status = STATUS_DONE;
		pos = 0;
		while (pos < shadow_table.size() && $signed(shadow_table[pos]) < $signed(op.value))
			pos++;
		case (op.kind)
			KIND_INSERT: begin
				if (shadow_table.size() >= DEPTH)
					r.status = STATUS_FULL;
				else
					shadow_table.insert(pos, op.value);
			end
			KIND_SEARCH, KIND_REMOVE: begin
				if (pos < shadow_table.size() && shadow_table[pos] == op.value) begin
					r.found = 1'b1;
					if (op.kind == KIND_REMOVE)
						shadow_table.delete(pos);
				end else begin
					r.status = STATUS_ABSENT;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_table.size());
		r.empty = (shadow_table.size() == 0);
		return r;
	endfunction

	task automatic queue_op(kind_t kind, logic signed [VALUE_W-1:0] value);
		table_op_t op;
		op.kind  = kind;
		op.value = value;
		pending_ops.push_back(op);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: new beats and rsp ready change on the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || ($urandom_range(99) >= 33);
			if (!req_ch.valid || beat_taken) begin
				if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
					req_ch.valid <= 1'b1;
					req_ch.kind  <= pending_ops[0].kind;
					req_ch.value <= pending_ops[0].value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: request and response beats are sampled on the rising edge.
	always @(posedge clk) begin
		table_op_t op;
		outcome_t  exp_r;
		cyc <= cyc + 1;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			op = pending_ops.pop_front();
			expected_outcomes.push_back(apply_op(op));
			ops_taken  <= ops_taken + 1;
			beat_taken <= 1'b1;
		end else begin
			beat_taken <= 1'b0;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_outcomes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected rsp beat found=%0b status=%0d count=%0d empty=%0b",
						$time, rsp_ch.found, rsp_ch.status, rsp_ch.entry_count,
						rsp_ch.is_empty);
			end else begin
				exp_r = expected_outcomes.pop_front();
				if (rsp_ch.found !== exp_r.found || rsp_ch.status !== exp_r.status ||
						rsp_ch.entry_count !== exp_r.count || rsp_ch.is_empty !== exp_r.empty) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: mismatch exp found=%0b status=%0d count=%0d empty=%0b",
							$time, exp_r.found, exp_r.status, exp_r.count, exp_r.empty,
							", got found=%0b status=%0d count=%0d empty=%0b",
							rsp_ch.found, rsp_ch.status, rsp_ch.entry_count, rsp_ch.is_empty);
				end
			end
		end
	end

	initial begin
		wait (cyc >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic signed [VALUE_W-1:0] pool[6];
		int                        n_real;
		int                        seg;
		int                        last_seg;
		int                        roll;
		int                        w_ins;
		int                        w_rem;
		kind_t                     kind;
		logic signed [VALUE_W-1:0] value;

		cyc          = 0;
		ops_taken    = 0;
		errors       = 0;
		beat_taken   = 1'b0;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind  = KIND_INSERT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// directed: empty table, extremes, duplicates, fill to full, head/tail removal
		queue_op(KIND_REMOVE, 32'sd5);
		queue_op(KIND_UNUSED, 32'sd5);
		queue_op(KIND_INSERT, 32'sd0);
		queue_op(KIND_INSERT, 32'h7fff_ffff);
		queue_op(KIND_INSERT, 32'h8000_0000);
		queue_op(KIND_INSERT, -32'sd1);
		queue_op(KIND_INSERT, 32'sd0);
		for (int i = 0; i < 11; i++)
			queue_op(KIND_INSERT, $urandom);
		queue_op(KIND_INSERT, 32'sd7);
		queue_op(KIND_SEARCH, 32'h8000_0000);
		queue_op(KIND_REMOVE, 32'h8000_0000);
		queue_op(KIND_REMOVE, 32'sd0);
		queue_op(KIND_REMOVE, 32'h7fff_ffff);
		queue_op(KIND_SEARCH, 32'h7fff_ffff);
		queue_op(KIND_UNUSED, 32'hffff_ffff);

		// random: alternating fill-heavy and drain-heavy segments over a small value pool
		n_real   = 0;
		last_seg = -1;
		while (n_real < RANDOM_OPS) begin
			seg = n_real / 40;
			if (seg != last_seg) begin
				last_seg = seg;
				foreach (pool[i])
					pool[i] = ($urandom_range(1) == 0) ? $urandom
						: $signed($urandom_range(8)) - 4;
			end
			w_ins = (seg % 2 == 0) ? 60 : 25;
			w_rem = (seg % 2 == 0) ? 25 : 60;
			roll  = $urandom_range(99);
			value = ($urandom_range(99) < 70) ? pool[$urandom_range(5)] : $urandom;
			if ($urandom_range(99) < 3) begin
				queue_op(KIND_UNUSED, value);
			end else begin
				if (roll < w_ins)
					kind = KIND_INSERT;
				else if (roll < w_ins + w_rem)
					kind = KIND_REMOVE;
				else
					kind = KIND_SEARCH;
				queue_op(kind, value);
				n_real++;
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		#5 arst_n = 1'b1;

		wait (pending_ops.size() == 0);
		wait (expected_outcomes.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
